/* hdl/rcss_pkg.sv */
package rcss_pkg;

   // Width of a time stamp in the block, default
   localparam int TIME_BITS_DEFAULT = 32;

   // Fixed field widths
   localparam int NOW_BITS = 32;
   localparam int DUR_BITS = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int NUM_CFG = 6;

   // Timing constants in ms
   localparam int HOLD_TO_SWITCH_MS = 700;
   localparam int PAUSE_ON_CONNECT_MS = 3000;
   localparam int RESTART_HOLDOFF_MS = 600;
   localparam logic [DUR_BITS-1:0] CTRL_OFF_MS = 16'd1000;

   // Event codes
   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_CONNECT = 2'd1;
   localparam logic [1:0] ACT_DISCONNECT = 2'd2;

   // Radio mode codes
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_BT = 2'd1;
   localparam logic [1:0] MODE_WIFI = 2'd2;

   // Mode step counter values that select a mode
   localparam logic [1:0] STEP_NORMAL = 2'd0;
   localparam logic [1:0] STEP_BT = 2'd2;

   // Wifi request codes
   localparam logic [1:0] WIFI_NONE = 2'd0;
   localparam logic [1:0] WIFI_ENABLE = 2'd1;
   localparam logic [1:0] WIFI_DISABLE = 2'd2;

   // LED codes
   localparam logic [2:0] LED_NONE = 3'd0;
   localparam logic [2:0] LED_DIM_WHITE = 3'd1;
   localparam logic [2:0] LED_BLUE = 3'd2;
   localparam logic [2:0] LED_ORANGE = 3'd3;
   localparam logic [2:0] LED_GREEN = 3'd4;
   localparam logic [2:0] LED_RED = 3'd5;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CFG_ON_NORMAL = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_OFF_NORMAL = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_ON_STA = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_OFF_STA = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_ON_AP = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_OFF_AP = 3'd5;

   typedef logic [DUR_BITS-1:0] dur_type;
   typedef dur_type [NUM_CFG-1:0] cfg_type;

   localparam cfg_type CFG_RESET = '{
      16'd1900, 16'd100, 16'd850, 16'd150, 16'd500, 16'd500
   };

   // One result item
   typedef struct packed {
      logic [1:0] radio_mode;
      logic       scan_enabled;
      logic       scan_cmd_issued;
      logic       scan_cmd_value;
      logic [1:0] wifi_request;
      logic [2:0] led_code;
      logic       disconnect_all;
      logic       duty_on;
   } rsp_type;

   // Reset duty durations
   localparam dur_type DUR_RESET = 16'd500;

endpackage

/* hdl/radio_coexistence_scan_scheduler.sv */
// Radio coexistence scan scheduler. Each accepted event (tick, controller
// connect, controller disconnect) updates the radio mode, the wifi pause,
// the scan hold-off and the scan duty cycle, and yields exactly one result.
// One event is accepted per clock; it is held in the input register, its
// whole update is done combinationally from there, and its result is
// then held in the result register (one input register, one result
// register) until it is transferred. A
// stalled result register backs up into req_stall, so throughput is one
// event per cycle whenever the result side keeps up. Register writes are
// always ready and must only be made while no event is in flight. Time
// compares are unsigned and do not handle wrap; sums wrap at TIME_BITS.
module radio_coexistence_scan_scheduler #(
   parameter int TIME_BITS = rcss_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // event channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_action,
   input  logic [rcss_pkg::NOW_BITS-1:0]         req_now_ms,
   input  logic                                  req_button_pressed,
   input  logic                                  req_any_controller,
   input  logic                                  req_sta_connecting,
   input  logic                                  req_ap_active,
   input  logic                                  req_wifi_off,
   input  logic                                  req_slot_matched,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_radio_mode,
   output logic                                  rsp_scan_enabled,
   output logic                                  rsp_scan_cmd_issued,
   output logic                                  rsp_scan_cmd_value,
   output logic [1:0]                            rsp_wifi_request,
   output logic [2:0]                            rsp_led_code,
   output logic                                  rsp_disconnect_all,
   output logic                                  rsp_duty_on,
   // register write port
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rcss_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rcss_pkg::DUR_BITS-1:0]         csr_wdata
);

   localparam int TW = TIME_BITS;

   typedef logic [TW-1:0] tstamp_type;

   // Configuration registers
   rcss_pkg::cfg_type cfg_ff;

   // Input register
   logic       in_valid_ff;
   logic [1:0] act_ff;
   logic [rcss_pkg::NOW_BITS-1:0] now_ff;
   logic       btn_ff, any_ff, sta_ff, ap_ff, woff_ff, matched_ff;

   // Scheduler state
   logic [1:0]        mode_now_ff, mode_now_in;
   logic [1:0]        mode_applied_ff, mode_applied_in;
   logic [1:0]        step_cnt_ff, step_cnt_in;
   tstamp_type        press_start_ff, press_start_in;
   logic              long_press_ff, long_press_in;
   tstamp_type        pause_until_ff, pause_until_in;
   logic              paused_bt_ff, paused_bt_in;
   tstamp_type        holdoff_until_ff, holdoff_until_in;
   logic              scan_flag_ff, scan_flag_in;
   tstamp_type        next_toggle_ff, next_toggle_in;
   rcss_pkg::dur_type on_ms_ff, on_ms_in;
   rcss_pkg::dur_type off_ms_ff, off_ms_in;
   logic              duty_on_ff, duty_on_in;

   // Result register
   logic              rsp_valid_ff;
   rcss_pkg::rsp_type rsp_ff, rsp_in;

   logic load_rsp;
   logic fire;

   // Handshake: the result register takes a new value when empty or drained
   assign load_rsp  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && load_rsp;
   assign req_stall = in_valid_ff && !load_rsp;
   assign csr_ready = 1'b1;

   // Register writes, indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= rcss_pkg::CFG_RESET;
      end else if (csr_valid && csr_index < rcss_pkg::CSR_INDEX_BITS'(rcss_pkg::NUM_CFG)) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         act_ff     <= req_action;
         now_ff     <= req_now_ms;
         btn_ff     <= req_button_pressed;
         any_ff     <= req_any_controller;
         sta_ff     <= req_sta_connecting;
         ap_ff      <= req_ap_active;
         woff_ff    <= req_wifi_off;
         matched_ff <= req_slot_matched;
      end
   end

   // Event update
   always_comb begin
      logic [63:0]       now64;
      tstamp_type        now_t;
      rcss_pkg::dur_type ton, toff;
      logic              cmd_issued, cmd_value, disc_all;
      logic [1:0]        wifi_req;
      logic [2:0]        led;

      now64 = {32'b0, now_ff};
      now_t = now64[TW-1:0];
      ton   = '0;
      toff  = '0;

      mode_now_in      = mode_now_ff;
      mode_applied_in  = mode_applied_ff;
      step_cnt_in      = step_cnt_ff;
      press_start_in   = press_start_ff;
      long_press_in    = long_press_ff;
      pause_until_in   = pause_until_ff;
      paused_bt_in     = paused_bt_ff;
      holdoff_until_in = holdoff_until_ff;
      scan_flag_in     = scan_flag_ff;
      next_toggle_in   = next_toggle_ff;
      on_ms_in         = on_ms_ff;
      off_ms_in        = off_ms_ff;
      duty_on_in       = duty_on_ff;

      cmd_issued = 1'b0;
      cmd_value  = 1'b0;
      disc_all   = 1'b0;
      wifi_req   = rcss_pkg::WIFI_NONE;
      led        = rcss_pkg::LED_NONE;

      case (act_ff)
         rcss_pkg::ACT_TICK: begin
            // button hold detection and mode stepping
            if (btn_ff) begin
               if (press_start_ff == '0) begin
                  press_start_in = now_t;
                  long_press_in  = 1'b0;
               end else if (!long_press_ff &&
                            (now_t - press_start_ff) >= TW'(rcss_pkg::HOLD_TO_SWITCH_MS)) begin
                  step_cnt_in = step_cnt_ff + 2'd1;
                  if (step_cnt_in == rcss_pkg::STEP_NORMAL) begin
                     mode_now_in = rcss_pkg::MODE_NORMAL;
                  end else if (step_cnt_in == rcss_pkg::STEP_BT) begin
                     mode_now_in = rcss_pkg::MODE_BT;
                  end else begin
                     mode_now_in = rcss_pkg::MODE_WIFI;
                  end
                  long_press_in = 1'b1;
               end
            end else begin
               press_start_in = '0;
               long_press_in  = 1'b0;
            end

            // apply a new mode once
            if (mode_now_in != mode_applied_ff) begin
               mode_applied_in = mode_now_in;
               cmd_issued      = 1'b1;
               if (mode_now_in == rcss_pkg::MODE_NORMAL) begin
                  wifi_req       = rcss_pkg::WIFI_ENABLE;
                  cmd_value      = 1'b0;
                  scan_flag_in   = 1'b0;
                  duty_on_in     = 1'b0;
                  next_toggle_in = now_t;
                  led            = rcss_pkg::LED_DIM_WHITE;
               end else if (mode_now_in == rcss_pkg::MODE_BT) begin
                  wifi_req     = rcss_pkg::WIFI_DISABLE;
                  cmd_value    = 1'b1;
                  scan_flag_in = 1'b1;
                  duty_on_in   = 1'b1;
                  led          = rcss_pkg::LED_BLUE;
               end else begin
                  disc_all     = 1'b1;
                  cmd_value    = 1'b0;
                  scan_flag_in = 1'b0;
                  duty_on_in   = 1'b0;
                  wifi_req     = rcss_pkg::WIFI_ENABLE;
                  led          = rcss_pkg::LED_ORANGE;
               end
            end

            // wifi pause after a connect
            if (mode_now_in == rcss_pkg::MODE_NORMAL) begin
               if (pause_until_ff > now_t) begin
                  if (!paused_bt_ff) begin
                     wifi_req = rcss_pkg::WIFI_DISABLE;
                     if (!any_ff) begin
                        cmd_issued = 1'b1;
                        cmd_value  = 1'b1;
                     end
                     paused_bt_in = 1'b1;
                  end
               end else if (paused_bt_ff) begin
                  wifi_req     = rcss_pkg::WIFI_ENABLE;
                  paused_bt_in = 1'b0;
               end
            end else if (paused_bt_ff) begin
               paused_bt_in   = 1'b0;
               pause_until_in = '0;
            end

            // scan control by mode
            if (mode_now_in == rcss_pkg::MODE_BT) begin
               if (!scan_flag_in) begin
                  cmd_issued   = 1'b1;
                  cmd_value    = 1'b1;
                  scan_flag_in = 1'b1;
               end
            end else if (mode_now_in == rcss_pkg::MODE_WIFI) begin
               if (scan_flag_in) begin
                  cmd_issued   = 1'b1;
                  cmd_value    = 1'b0;
                  scan_flag_in = 1'b0;
                  duty_on_in   = 1'b0;
               end
            end else if (woff_ff) begin
               if (!any_ff) begin
                  if (!scan_flag_in) begin
                     cmd_issued   = 1'b1;
                     cmd_value    = 1'b1;
                     scan_flag_in = 1'b1;
                     duty_on_in   = 1'b1;
                  end
               end else if (scan_flag_in) begin
                  cmd_issued   = 1'b1;
                  cmd_value    = 1'b0;
                  scan_flag_in = 1'b0;
                  duty_on_in   = 1'b0;
               end
            end else begin
               // duty cycle durations by scenario
               if (any_ff) begin
                  ton  = '0;
                  toff = rcss_pkg::CTRL_OFF_MS;
               end else if (ap_ff) begin
                  ton  = cfg_ff[rcss_pkg::CFG_ON_AP];
                  toff = cfg_ff[rcss_pkg::CFG_OFF_AP];
               end else if (sta_ff) begin
                  ton  = cfg_ff[rcss_pkg::CFG_ON_STA];
                  toff = cfg_ff[rcss_pkg::CFG_OFF_STA];
               end else begin
                  ton  = cfg_ff[rcss_pkg::CFG_ON_NORMAL];
                  toff = cfg_ff[rcss_pkg::CFG_OFF_NORMAL];
               end

               // scenario change restarts the cycle in the off phase
               if (ton != on_ms_ff || toff != off_ms_ff) begin
                  on_ms_in       = ton;
                  off_ms_in      = toff;
                  duty_on_in     = 1'b0;
                  scan_flag_in   = 1'b0;
                  cmd_issued     = 1'b1;
                  cmd_value      = 1'b0;
                  next_toggle_in = now_t + TW'(toff);
               end

               if (any_ff || now_t >= holdoff_until_ff) begin
                  if (!any_ff) begin
                     if (now_t >= next_toggle_in) begin
                        if (!duty_on_in) begin
                           scan_flag_in = (on_ms_in != '0);
                           cmd_issued   = 1'b1;
                           cmd_value    = scan_flag_in;
                           duty_on_in   = 1'b1;
                           if (on_ms_in != '0) begin
                              next_toggle_in = now_t + TW'(on_ms_in);
                           end else begin
                              next_toggle_in = now_t + TW'(off_ms_in);
                           end
                        end else begin
                           scan_flag_in   = 1'b0;
                           cmd_issued     = 1'b1;
                           cmd_value      = 1'b0;
                           duty_on_in     = 1'b0;
                           next_toggle_in = now_t + TW'(off_ms_in);
                        end
                     end
                  end else if (scan_flag_in) begin
                     cmd_issued     = 1'b1;
                     cmd_value      = 1'b0;
                     scan_flag_in   = 1'b0;
                     duty_on_in     = 1'b0;
                     next_toggle_in = now_t + TW'(rcss_pkg::CTRL_OFF_MS);
                  end
               end
            end
         end
         rcss_pkg::ACT_CONNECT: begin
            if (matched_ff) begin
               led = rcss_pkg::LED_GREEN;
               if (mode_now_ff == rcss_pkg::MODE_NORMAL) begin
                  pause_until_in = now_t + TW'(rcss_pkg::PAUSE_ON_CONNECT_MS);
               end
            end
         end
         rcss_pkg::ACT_DISCONNECT: begin
            if (matched_ff) begin
               led              = rcss_pkg::LED_RED;
               holdoff_until_in = now_t + TW'(rcss_pkg::RESTART_HOLDOFF_MS);
            end
         end
         default: begin
            // unused code leaves everything as is
         end
      endcase

      rsp_in.radio_mode      = mode_now_in;
      rsp_in.scan_enabled    = scan_flag_in;
      rsp_in.scan_cmd_issued = cmd_issued;
      rsp_in.scan_cmd_value  = cmd_issued & cmd_value;
      rsp_in.wifi_request    = wifi_req;
      rsp_in.led_code        = led;
      rsp_in.disconnect_all  = disc_all;
      rsp_in.duty_on         = duty_on_in;
   end

   // State update on each event transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_now_ff      <= rcss_pkg::MODE_NORMAL;
         mode_applied_ff  <= rcss_pkg::MODE_NORMAL;
         step_cnt_ff      <= rcss_pkg::STEP_NORMAL;
         press_start_ff   <= '0;
         long_press_ff    <= 1'b0;
         pause_until_ff   <= '0;
         paused_bt_ff     <= 1'b0;
         holdoff_until_ff <= '0;
         scan_flag_ff     <= 1'b0;
         next_toggle_ff   <= '0;
         on_ms_ff         <= rcss_pkg::DUR_RESET;
         off_ms_ff        <= rcss_pkg::DUR_RESET;
         duty_on_ff       <= 1'b0;
      end else if (fire) begin
         mode_now_ff      <= mode_now_in;
         mode_applied_ff  <= mode_applied_in;
         step_cnt_ff      <= step_cnt_in;
         press_start_ff   <= press_start_in;
         long_press_ff    <= long_press_in;
         pause_until_ff   <= pause_until_in;
         paused_bt_ff     <= paused_bt_in;
         holdoff_until_ff <= holdoff_until_in;
         scan_flag_ff     <= scan_flag_in;
         next_toggle_ff   <= next_toggle_in;
         on_ms_ff         <= on_ms_in;
         off_ms_ff        <= off_ms_in;
         duty_on_ff       <= duty_on_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_radio_mode      = rsp_ff.radio_mode;
   assign rsp_scan_enabled    = rsp_ff.scan_enabled;
   assign rsp_scan_cmd_issued = rsp_ff.scan_cmd_issued;
   assign rsp_scan_cmd_value  = rsp_ff.scan_cmd_value;
   assign rsp_wifi_request    = rsp_ff.wifi_request;
   assign rsp_led_code        = rsp_ff.led_code;
   assign rsp_disconnect_all  = rsp_ff.disconnect_all;
   assign rsp_duty_on         = rsp_ff.duty_on;

   // A new mode is always applied in the same event that selects it
   a_mode_applied: assert property (@(posedge clock) disable iff (reset)
      mode_applied_ff == mode_now_ff)
      else $error("mode selected but not applied");

   // The wifi pause only exists in normal mode
   a_pause_normal: assert property (@(posedge clock) disable iff (reset)
      paused_bt_ff |-> mode_now_ff == rcss_pkg::MODE_NORMAL)
      else $error("wifi pause held outside normal mode");

   // Bluetooth-only mode always reports scanning on
   a_bt_scans: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.radio_mode == rcss_pkg::MODE_BT |-> rsp_ff.scan_enabled)
      else $error("scan off in bluetooth-only mode");

   // Drop-all only on entering wifi-only mode
   a_disc_wifi: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.disconnect_all |->
         rsp_ff.radio_mode == rcss_pkg::MODE_WIFI && rsp_ff.led_code == rcss_pkg::LED_ORANGE)
      else $error("disconnect-all outside wifi-only entry");

   // A command value without a command is never reported
   a_cmd_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.scan_cmd_issued |-> !rsp_ff.scan_cmd_value)
      else $error("scan command value without command");

endmodule
